FILE: sv/websocket_frame_deframer_macros.svh
// ------------------------------------------------------------------------
// websocket_frame_deframer assertion macros
// Shared concurrent assertion forms for the frame deframer modules.
// ------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while in reset
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

FILE: sv/wsd_pkg.sv
// ------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // Width of the payload length that the frame can carry
    localparam int LEN_BITS = 64;
    // Width of the length accumulator (64-bit extended length field)
    localparam int EXT_BITS = 64;
    localparam logic [EXT_BITS-1:0] LEN_MAX = EXT_BITS'({EXT_BITS{1'b1}} >> (EXT_BITS - LEN_BITS));

    // 7-bit length escape codes
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Index of the last header byte of each multi-byte field
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // Input word actions
    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_RESYNC = 1'b1;

    typedef enum logic [5:0] {
        PH_HDR0  = 6'b000001,
        PH_HDR1  = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_EXT64 = 6'b001000,
        PH_KEY   = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       was_masked;
        logic       last_of_frame;
    } t_out_word;

    // Parser result toward the output register
    typedef struct packed {
        logic      vld;
        t_out_word word;
    } t_parse_res;

endpackage

`default_nettype wire

FILE: sv/wsd_parser.sv
// ------------------------------------------------------------------------
// wsd_parser
// Header parser and payload unmasker: one stream byte per accepted word.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_fire,
    input  wire t_in_word   i_word,
    output t_parse_res      o_res
);

    t_phase                r_phase,  n_phase;
    logic [3:0]            r_opcode, n_opcode;
    logic                  r_fin,    n_fin;
    logic                  r_masked, n_masked;
    logic [EXT_BITS-1:0]   r_len,    n_len;
    logic [2:0]            r_cnt,    n_cnt;
    logic [31:0]           r_key,    n_key;
    logic [1:0]            r_idx,    n_idx;

    logic [7:0]            w_byte;
    logic [7:0]            w_key_byte;
    logic [EXT_BITS-1:0]   w_dec;
    logic                  len_done;
    logic                  hdr_done;

    assign w_byte = i_word.rx_byte;

    // Key byte for this payload position; first key byte received is index 0
    always_comb begin
        case (r_idx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    assign w_dec = (r_len != '0) ? (r_len - EXT_BITS'(1)) : r_len;

    // Next state and result
    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_idx    = r_idx;
        len_done = 1'b0;
        hdr_done = 1'b0;
        o_res    = '0;

        if (i_word.action == ACT_RESYNC) begin
            n_phase = PH_HDR0;
            n_cnt   = '0;
            n_idx   = '0;
        end else begin
            case (r_phase)
                PH_HDR1: begin
                    n_masked = w_byte[7];
                    n_cnt    = '0;
                    n_len    = '0;
                    if (w_byte[6:0] == LEN7_EXT64) begin
                        n_phase = PH_EXT64;
                    end else if (w_byte[6:0] == LEN7_EXT16) begin
                        n_phase = PH_EXT16;
                    end else begin
                        n_len    = EXT_BITS'(w_byte[6:0]);
                        len_done = 1'b1;
                    end
                end
                PH_EXT16: begin
                    n_len = EXT_BITS'({r_len[7:0], w_byte});
                    if (r_cnt >= EXT16_LAST) begin
                        len_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_EXT64: begin
                    n_len = {r_len[EXT_BITS-9:0], w_byte};
                    if (r_cnt >= EXT64_LAST) begin
                        if (n_len > LEN_MAX) begin
                            n_len = LEN_MAX;
                        end
                        len_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_KEY: begin
                    n_key = {r_key[23:0], w_byte};
                    if (r_cnt >= KEY_LAST) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
                PH_DATA: begin
                    n_idx = r_idx + 2'd1;
                    n_len = w_dec;
                    o_res.vld               = 1'b1;
                    o_res.word.has_data     = 1'b1;
                    o_res.word.payload_byte = r_masked ? (w_byte ^ w_key_byte) : w_byte;
                    if (w_dec == '0) begin
                        n_phase = PH_HDR0;
                        o_res.word.last_of_frame = 1'b1;
                    end
                end
                default: begin
                    // header byte zero, also any phase code of no meaning
                    n_fin    = w_byte[7];
                    n_opcode = w_byte[3:0];
                    n_cnt    = '0;
                    n_phase  = PH_HDR1;
                end
            endcase

            // Length known: read the key or finish the header
            if (len_done) begin
                n_cnt = '0;
                if (n_masked) begin
                    n_phase = PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: empty frame gives its event now
            if (hdr_done) begin
                n_cnt = '0;
                n_idx = '0;
                if (n_len == '0) begin
                    n_phase = PH_HDR0;
                    o_res.vld                = 1'b1;
                    o_res.word.last_of_frame = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
        end

        o_res.word.frame_opcode   = n_opcode;
        o_res.word.final_fragment = n_fin;
        o_res.word.was_masked     = n_masked;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_idx    <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_idx    <= n_idx;
        end
    end

    // Resync always lands on header byte zero
    `WSD_ASSERT_NEXT(a_resync_hdr0, i_clk, i_rst_n,
        i_fire && (i_word.action == ACT_RESYNC), r_phase == PH_HDR0)
    // Final payload byte or empty-frame event ends the frame
    `WSD_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n,
        i_fire && o_res.vld && o_res.word.last_of_frame, r_phase == PH_HDR0)

endmodule

`default_nettype wire

FILE: sv/websocket_frame_deframer.sv
// ------------------------------------------------------------------------
// websocket_frame_deframer
// RFC 6455 receive frame parser: header decode and payload unmasking.
// ------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Word
//  in       input      i_in_valid / o_in_stall    t_in_word  (action, rx_byte)
//  out      output     o_out_valid / i_out_stall  t_out_word (payload byte + tags)
//
//  One stream byte accepted per clock while input is not stalled; its result, if any, is shown the next cycle.
//  The parser state update and the 64-bit length decrement sit between the input
//  handshake and the output register.
//  Synchronous active-low reset returns the parser to header byte zero.
//  Input stalls only while a result is held in the output register and out stalls.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    logic       r_out_valid;
    t_out_word  r_out_word;
    logic       in_fire;
    t_parse_res parse_res;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_fire    = i_in_valid && !o_in_stall;

    wsd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_word  (i_in_word),
        .o_res   (parse_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= parse_res.vld;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_word <= parse_res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Empty-frame events close their frame
    `WSD_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n,
        o_out_valid && !o_out_word.has_data, o_out_word.last_of_frame)
    // No payload byte on an empty-frame event
    `WSD_ASSERT_NOW(a_empty_zero_byte, i_clk, i_rst_n,
        o_out_valid && !o_out_word.has_data, o_out_word.payload_byte == 8'd0)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for websocket_frame_deframer. Streams directed and
// random RFC 6455 frames (short, 16-bit and 64-bit lengths, masked and
// unmasked, cut-off frames, resyncs and noise) one byte per word, predicts
// every output word with its payload unmasked, and checks each in order. Both
// channels idle in random bursts, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import wsd_pkg::*;

    localparam int TOTAL_ITEMS  = 430;
    localparam int QUIET_ITEMS  = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTS   = 30;

    // Length field encodings used when building headers
    localparam int LEN_SHORT = 0;
    localparam int LEN_16    = 1;
    localparam int LEN_64    = 2;

    // Tracks the parser state and the payload words it should emit
    class deframe_scoreboard;
        t_phase      phase     = PH_HDR0;
        logic [3:0]  opcode    = '0;
        logic        fin       = 1'b0;
        logic        masked    = 1'b0;
        logic [63:0] remaining = '0;
        logic [2:0]  hdr_cnt   = '0;
        logic [31:0] key       = '0;
        logic [1:0]  key_idx   = '0;
        t_out_word   payload_queue[$];
        int          errors    = 0;

        function t_out_word tag_word(logic [7:0] v, logic has, logic last);
            t_out_word w;
            w.payload_byte   = v;
            w.has_data       = has;
            w.frame_opcode   = opcode;
            w.final_fragment = fin;
            w.was_masked     = masked;
            w.last_of_frame  = last;
            return w;
        endfunction

        // Header fully read: either an empty-frame event or on to payload
        function bit finish_header(output t_out_word w);
            hdr_cnt = '0;
            key_idx = '0;
            w = '0;
            if (remaining == 0) begin
                phase = PH_HDR0;
                w = tag_word(8'h00, 1'b0, 1'b1);
                return 1'b1;
            end
            phase = PH_DATA;
            return 1'b0;
        endfunction

        function bit finish_length(output t_out_word w);
            hdr_cnt = '0;
            w = '0;
            if (masked) begin
                phase = PH_KEY;
                return 1'b0;
            end
            return finish_header(w);
        endfunction

        function void parse_byte(t_in_word in_w);
            t_out_word  w;
            bit         got;
            logic [7:0] b;
            logic [7:0] v;
            got = 1'b0;
            w = '0;
            b = in_w.rx_byte;
            if (in_w.action == ACT_RESYNC) begin
                phase = PH_HDR0;
                hdr_cnt = '0;
                key_idx = '0;
            end else begin
                case (phase)
                    PH_HDR1: begin
                        masked = b[7];
                        hdr_cnt = '0;
                        remaining = '0;
                        if (b[6:0] == LEN7_EXT64) begin
                            phase = PH_EXT64;
                        end else if (b[6:0] == LEN7_EXT16) begin
                            phase = PH_EXT16;
                        end else begin
                            remaining = 64'(b[6:0]);
                            got = finish_length(w);
                        end
                    end
                    PH_EXT16: begin
                        remaining = {48'd0, remaining[7:0], b};
                        if (hdr_cnt >= EXT16_LAST) got = finish_length(w);
                        else hdr_cnt++;
                    end
                    PH_EXT64: begin
                        remaining = {remaining[55:0], b};
                        if (hdr_cnt >= EXT64_LAST) begin
                            if (remaining > LEN_MAX) remaining = LEN_MAX;
                            got = finish_length(w);
                        end else begin
                            hdr_cnt++;
                        end
                    end
                    PH_KEY: begin
                        // first key byte received lands in the top byte
                        key = {key[23:0], b};
                        if (hdr_cnt >= KEY_LAST) got = finish_header(w);
                        else hdr_cnt++;
                    end
                    PH_DATA: begin
                        v = b;
                        if (masked) v = v ^ key[8*(3 - key_idx) +: 8];
                        key_idx++;
                        if (remaining > 0) remaining--;
                        if (remaining == 0) phase = PH_HDR0;
                        w = tag_word(v, 1'b1, remaining == 0);
                        got = 1'b1;
                    end
                    default: begin
                        // header byte zero; RSV bits ignored
                        fin = b[7];
                        opcode = b[3:0];
                        hdr_cnt = '0;
                        phase = PH_HDR1;
                    end
                endcase
            end
            if (got) payload_queue.push_back(w);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task compare_payload(t_out_word got);
            t_out_word want;
            if (payload_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = payload_queue.pop_front();
                if (got.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              got.payload_byte, want.payload_byte));
                if (got.has_data !== want.has_data)
                    report_mismatch($sformatf("has_data %b, want %b",
                                              got.has_data, want.has_data));
                if (got.frame_opcode !== want.frame_opcode)
                    report_mismatch($sformatf("frame_opcode %h, want %h",
                                              got.frame_opcode, want.frame_opcode));
                if (got.final_fragment !== want.final_fragment)
                    report_mismatch($sformatf("final_fragment %b, want %b",
                                              got.final_fragment, want.final_fragment));
                if (got.was_masked !== want.was_masked)
                    report_mismatch($sformatf("was_masked %b, want %b",
                                              got.was_masked, want.was_masked));
                if (got.last_of_frame !== want.last_of_frame)
                    report_mismatch($sformatf("last_of_frame %b, want %b",
                                              got.last_of_frame, want.last_of_frame));
            end
        endtask

        function int pending();
            return payload_queue.size();
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    deframe_scoreboard sb = new;
    int sent        = 0;
    int gap_pct     = 0;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;

    websocket_frame_deframer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Handshake monitor: predict on input words, check output words, watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.parse_byte(in_word);
            if (out_valid && !out_stall) sb.compare_payload(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Output side: random stall bursts, plus one long hold on request
    initial begin
        int n;
        int pct;
        int span;
        pct = 0;
        span = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (!quiet && $urandom_range(0, 99) < pct) begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                @(posedge clk);
            end
            span++;
            if (span % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: pct = 0;
                    1: pct = 15;
                    default: pct = 50;
                endcase
            end
        end
    end

    // Offer one word and hold it until taken
    task automatic send_word(input logic act, input logic [7:0] b);
        t_in_word w;
        int       n;
        w.action = act;
        w.rx_byte = b;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        if (sent % 64 == 0) begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 50;
            endcase
        end
    endtask

    // Header, optional extended length, optional key, then n_data payload bytes
    task automatic send_frame(input logic [7:0] b0, input logic mask_on, input int mode,
                              input logic [63:0] len, input logic [31:0] mkey,
                              input int n_data);
        logic [7:0] b1;
        case (mode)
            LEN_SHORT: b1 = {mask_on, len[6:0]};
            LEN_16:    b1 = {mask_on, LEN7_EXT16};
            default:   b1 = {mask_on, LEN7_EXT64};
        endcase
        send_word(ACT_BYTE, b0);
        send_word(ACT_BYTE, b1);
        if (mode == LEN_16) begin
            for (int i = 1; i >= 0; i--) send_word(ACT_BYTE, len[8*i +: 8]);
        end else if (mode == LEN_64) begin
            for (int i = 7; i >= 0; i--) send_word(ACT_BYTE, len[8*i +: 8]);
        end
        if (mask_on) begin
            for (int i = 3; i >= 0; i--) send_word(ACT_BYTE, mkey[8*i +: 8]);
        end
        repeat (n_data) send_word(ACT_BYTE, 8'($urandom));
    endtask

    // Random frame; long frames and cut frames are closed by a resync
    task automatic random_frame(input bit cut);
        logic [63:0] len;
        int          mode;
        int          k;
        int          n;
        bit          chop;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            mode = LEN_SHORT;
            len = ($urandom_range(0, 19) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
        end else if (k < 85) begin
            mode = LEN_16;
            len = ($urandom_range(0, 7) == 0) ? 64'hFFFF : 64'($urandom_range(0, 10));
        end else begin
            mode = LEN_64;
            case ($urandom_range(0, 5))
                0: len = '1;
                1: len = {$urandom, $urandom};
                default: len = 64'($urandom_range(0, 10));
            endcase
        end
        chop = cut || (len > 64'd125);
        if (len > 64'd125) n = $urandom_range(1, 8);
        else if (cut && len > 0) n = $urandom_range(0, int'(len) - 1);
        else n = int'(len);
        send_frame(8'($urandom), 1'($urandom), mode, len, $urandom, n);
        if (chop) send_word(ACT_RESYNC, 8'($urandom));
    endtask

    initial begin
        int r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty frames, RSV bits, key order, resync, 16-bit length
        send_frame(8'h81, 1'b0, LEN_SHORT, 64'd0, 32'h0, 0);
        send_frame(8'h7F, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
        send_frame(8'h02, 1'b1, LEN_SHORT, 64'd2, 32'hA55A_0FF0, 2);
        send_word(ACT_BYTE, 8'h01);
        send_word(ACT_RESYNC, 8'hFF);
        send_frame(8'h88, 1'b0, LEN_16, 64'd1, 32'h0, 1);

        // Long output hold while a frame keeps streaming in
        hold_req = 1'b1;
        send_frame(8'h82, 1'b0, LEN_SHORT, 64'd40, 32'h0, 40);

        while (sent < TOTAL_ITEMS) begin
            if (sent >= TOTAL_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                random_frame(1'b0);
            end else if (r < 85) begin
                random_frame(1'b1);
            end else if (r < 93) begin
                // header broken off by a resync
                send_word(ACT_BYTE, 8'($urandom));
                repeat ($urandom_range(0, 4)) send_word(ACT_BYTE, 8'($urandom));
                send_word(ACT_RESYNC, 8'($urandom));
            end else begin
                // noise, then back to a clean header
                repeat ($urandom_range(1, 8))
                    send_word(($urandom_range(0, 3) == 0) ? ACT_RESYNC : ACT_BYTE,
                              8'($urandom));
                send_word(ACT_RESYNC, 8'($urandom));
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
